>>> hdl/ios_pkg.sv
package ios_pkg;

   localparam int CAPACITY = 64;

   localparam int OP_W      = 3;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 6;
   localparam int COUNT_O_W = 7;

   localparam int ID_W    = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   // Command broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                      compare_en;
      logic                      apply_en;
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
      logic [COUNT_W-1:0]        count;
   } ios_cmd_type;

endpackage

>>> hdl/ios_req_if.sv
interface ios_req_if;
   import ios_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic signed [VALUE_W-1:0] value;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, output operation, output value, output index, input ready);
   modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

>>> hdl/ios_rsp_if.sv
interface ios_rsp_if;
   import ios_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      was_member;
   logic                      changed;
   logic                      full_res;
   logic [COUNT_O_W-1:0]      count;
   logic signed [VALUE_W-1:0] read_value;
   logic                      read_valid;

   modport source (output valid, output was_member, output changed, output full_res,
                   output count, output read_value, output read_valid, input ready);
   modport sink   (input valid, input was_member, input changed, input full_res,
                   input count, input read_value, input read_valid, output ready);
endinterface

>>> hdl/ios_cell.sv
module ios_cell (
   input  logic                               clock,
   input  ios_pkg::ios_cmd_type               cmd,
   input  logic [ios_pkg::ID_W-1:0]           cell_id,
   input  logic                               hit_in,
   output logic                               hit_out,
   input  logic signed [ios_pkg::VALUE_W-1:0] next_data,
   output logic signed [ios_pkg::VALUE_W-1:0] data_out,
   input  logic [ios_pkg::VALUE_W-1:0]        rd_in,
   output logic [ios_pkg::VALUE_W-1:0]        rd_out
);
   import ios_pkg::*;

   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic                      sel_ff, sel_in;
   logic                      live;

   always_comb begin
      live   = 32'(cell_id) < 32'(cmd.count);
      sel_in = sel_ff;
      if (cmd.compare_en) begin
         if (cmd.op == OP_READ) begin
            sel_in = 32'(cmd.index) == 32'(cell_id);
         end else begin
            sel_in = live && (data_ff == cmd.value);
         end
      end
   end

   // A removal moves every cell at or after the matching one down by one place.
   always_comb begin
      data_in = data_ff;
      if (cmd.apply_en) begin
         case (cmd.op)
            OP_REMOVE: begin
               if (hit_in || sel_ff) data_in = next_data;
            end
            OP_ADD: begin
               if (32'(cell_id) == 32'(cmd.count)) data_in = cmd.value;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      sel_ff  <= sel_in;
   end

   assign hit_out  = hit_in | sel_ff;
   assign data_out = data_ff;
   assign rd_out   = rd_in | (sel_ff ? data_ff : '0);

endmodule

>>> hdl/insertion_ordered_set_store.sv
// Channel   Direction  Carries
// req_chan  in         operation, value, index
// rsp_chan  out        was_member, changed, full_res, count, read_value, read_valid
//
// After its transfer every item passes a compare state, in which all cells compare in
// parallel, then an update state, in which the cells shift or append and the result
// register loads. The request port is ready again in the cycle after the update, so a
// new item transfers only once the last is done, even while a result waits on rsp_chan.
// If the result register is still occupied, the update waits until it drains.
// Synchronous reset empties the set; cell contents are not cleared.
module insertion_ordered_set_store (
   input logic        clock,
   input logic        reset,
   ios_req_if.sink    req_chan,
   ios_rsp_if.source  rsp_chan
);
   import ios_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [INDEX_W-1:0]        index_ff, index_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      was_ff, was_in;
   logic                      chg_ff, chg_in;
   logic                      full_ff, full_in;
   logic [COUNT_O_W-1:0]      rcount_ff, rcount_in;
   logic signed [VALUE_W-1:0] rval_ff, rval_in;
   logic                      rvalid_ff, rvalid_in;

   logic                      accept;
   logic                      apply;
   logic                      member;
   logic                      read_ok;
   logic [31:0]               count_wide;
   ios_cmd_type               cmd;

   logic                      hit_chain [0:CAPACITY];
   logic [VALUE_W-1:0]        rd_chain  [0:CAPACITY];
   logic signed [VALUE_W-1:0] data_bus  [0:CAPACITY-1];

   assign hit_chain[0] = 1'b0;
   assign rd_chain[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] next_data;
      if (i == CAPACITY - 1) begin : g_last
         assign next_data = data_bus[i];
      end else begin : g_mid
         assign next_data = data_bus[i+1];
      end
      ios_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .cell_id   (ID_W'(i)),
         .hit_in    (hit_chain[i]),
         .hit_out   (hit_chain[i+1]),
         .next_data (next_data),
         .data_out  (data_bus[i]),
         .rd_in     (rd_chain[i]),
         .rd_out    (rd_chain[i+1])
      );
   end

   assign accept = req_chan.valid && req_chan.ready;
   assign apply  = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_chan.ready);
   assign member = hit_chain[CAPACITY];

   always_comb begin
      cmd.compare_en = (state_ff == S_CMP);
      cmd.apply_en   = apply;
      cmd.op         = op_ff;
      cmd.value      = value_ff;
      cmd.index      = index_ff;
      cmd.count      = count_ff;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      value_in = value_ff;
      index_in = index_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.operation;
               value_in = req_chan.value;
               index_in = req_chan.index;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      was_in       = 1'b0;
      chg_in       = 1'b0;
      full_in      = 1'b0;
      rvalid_in    = 1'b0;
      rval_in      = '0;
      read_ok      = 32'(index_ff) < 32'(count_ff);
      unique case (op_ff)
         OP_ADD: begin
            was_in = member;
            if (!member) begin
               if (32'(count_ff) < 32'(CAPACITY)) begin
                  count_in = count_ff + 1'b1;
                  chg_in   = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            was_in = member;
            chg_in = member;
            if (member) count_in = count_ff - 1'b1;
         end
         OP_QUERY: begin
            was_in = member;
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_READ: begin
            rvalid_in = read_ok;
            if (read_ok) rval_in = rd_chain[CAPACITY];
         end
         default: begin
         end
      endcase
      count_wide = 32'(count_in);
      rcount_in  = count_wide[COUNT_O_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (apply) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      index_ff <= index_in;
      if (apply) begin
         was_ff    <= was_in;
         chg_ff    <= chg_in;
         full_ff   <= full_in;
         rcount_ff <= rcount_in;
         rval_ff   <= rval_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.was_member = was_ff;
   assign rsp_chan.changed    = chg_ff;
   assign rsp_chan.full_res   = full_ff;
   assign rsp_chan.count      = rcount_ff;
   assign rsp_chan.read_value = rval_ff;
   assign rsp_chan.read_valid = rvalid_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("member count exceeds capacity");

   a_accept_to_compare : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CMP)
      else $error("accepted request did not enter the compare cycle");

   a_remove_count : assert property (@(posedge clock) disable iff (reset)
      (apply && op_ff == OP_REMOVE && member) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("removal of a member did not lower the count");

   a_result_from_apply : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_APPLY)
      else $error("result appeared without an update cycle");

endmodule
